// ===== design/sobth_pkg.sv =====
// sobth_pkg: shared types, register codes and constants of the sobel edge threshold block
// no dependencies; imported by every module of the block but sobth_ram
package sobth_pkg;

	localparam int MAX_WIDTH_DEF = 1024;

	// configuration register widths and reset values
	localparam int FW_BITS       = 11;
	localparam int FH_BITS       = 12;
	localparam int TH_BITS       = 11;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 12;

	localparam logic [FW_BITS-1:0] FRAME_WIDTH_RST    = 11'd640;
	localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RST   = 12'd480;
	localparam logic [TH_BITS-1:0] EDGE_THRESHOLD_RST = 11'd150;

	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_EDGE_THRESHOLD = 2'd2;

	// item kinds
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	// where the new window column comes from
	localparam logic [1:0] SRC_ROW0  = 2'd0; // first row: all three from the pixel
	localparam logic [1:0] SRC_ROW1  = 2'd1; // second row: top and mid from previous line
	localparam logic [1:0] SRC_FULL  = 2'd2; // both line stores plus the pixel
	localparam logic [1:0] SRC_DRAIN = 2'd3; // bottom row replicated from previous line

	localparam logic [7:0] EDGE_ON  = 8'd255;
	localparam logic [7:0] EDGE_OFF = 8'd0;

	localparam int OUT_DEPTH = 8;
	localparam int GRAD_BITS = 11;
	localparam int LINE_BITS = 16; // {prev, prev2}

	typedef logic [7:0] pix_t;

	// one window column: [0] top, [1] mid, [2] bottom
	typedef logic [2:0][7:0] col_t;

	typedef struct packed {
		logic kind;
		pix_t pixel_in;
	} in_item_t;

	typedef struct packed {
		pix_t edge_pixel;
		logic frame_last;
	} out_item_t;

	// per-transfer control from the sequencer to the window stage
	typedef struct packed {
		logic       valid;
		logic       wr;
		logic       push;
		logic       emit;
		logic       sel_l;
		logic       sel_r;
		logic       last;
		logic [1:0] src;
		pix_t       pix;
	} ctl_t;

	// neighbourhood handed to the gradient stages
	typedef struct packed {
		logic valid;
		logic last;
		col_t l;
		col_t r;
		pix_t m_top;
		pix_t m_bot;
	} win_t;

endpackage

// ===== design/sobth_ram.sv =====
// sobth_ram: generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module sobth_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/sobth_ctrl.sv =====
// sobth_ctrl: raster position counters, frame size latch and per-transfer decisions
// depends on sobth_pkg; drives the line memory read and the window stage control
module sobth_ctrl #(
	parameter int MAX_WIDTH = sobth_pkg::MAX_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  sobth_pkg::in_item_t              item,
	input  logic [sobth_pkg::FW_BITS-1:0]    frame_width,
	input  logic [sobth_pkg::FH_BITS-1:0]    frame_height,
	output logic                             rd_en,
	output logic [$clog2(MAX_WIDTH)-1:0]     rd_addr,
	output sobth_pkg::ctl_t                  ctl_s1,
	output logic [$clog2(MAX_WIDTH)-1:0]     addr_s1
);
	import sobth_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);

	logic [CW-1:0]      in_col_q, out_col_q, lat_w_q;
	logic [FH_BITS-1:0] in_row_q, out_row_q, lat_h_q;
	logic               drain_q;

	logic [CW-1:0]      in_col_d, out_col_d, lat_w_d;
	logic [FH_BITS-1:0] in_row_d, out_row_d, lat_h_d;
	logic               drain_d;

	logic [31:0]        fw32, w32;
	logic [CW-1:0]      w_new, w, c;
	logic [FH_BITS-1:0] h_new, h, r;
	logic [CW:0]        c_inc, oc_inc;
	logic [FH_BITS:0]   r_inc;
	logic               first, is_pix, is_flush, final_flush, c_zero, c_one;
	logic               emit, push, last;
	logic [1:0]         src;

	// size clamp for a new frame
	always_comb begin
		fw32 = 32'(frame_width);
		if (fw32 < 32'(2)) begin
			w32 = 32'(2);
		end else if (fw32 > 32'(MAX_WIDTH)) begin
			w32 = 32'(MAX_WIDTH);
		end else begin
			w32 = fw32;
		end
		w_new = w32[CW-1:0];
		h_new = (frame_height < FH_BITS'(2)) ? FH_BITS'(2) : frame_height;
	end

	always_comb begin
		first       = !drain_q && (in_row_q == '0) && (in_col_q == '0);
		w           = first ? w_new : lat_w_q;
		h           = first ? h_new : lat_h_q;
		c           = in_col_q;
		r           = in_row_q;
		c_inc       = {1'b0, c} + 1'b1;
		r_inc       = {1'b0, r} + 1'b1;
		oc_inc      = {1'b0, out_col_q} + 1'b1;
		is_pix      = accept && !drain_q && (item.kind == KIND_PIXEL);
		is_flush    = accept && drain_q && (item.kind == KIND_FLUSH);
		final_flush = is_flush && (c >= w);
		c_zero      = (c == '0);
		c_one       = (c == CW'(1));

		if (is_pix) begin
			emit = c_zero ? (r >= FH_BITS'(2)) : (r >= FH_BITS'(1));
		end else begin
			emit = is_flush;
		end
		push = is_pix || (is_flush && !final_flush);
		last = emit && (out_row_q == h - 1'b1) && (out_col_q == w - 1'b1);

		if (!is_pix) begin
			src = SRC_DRAIN;
		end else if (r == '0) begin
			src = SRC_ROW0;
		end else if (r == FH_BITS'(1)) begin
			src = SRC_ROW1;
		end else begin
			src = SRC_FULL;
		end

		in_col_d  = in_col_q;
		in_row_d  = in_row_q;
		out_col_d = out_col_q;
		out_row_d = out_row_q;
		lat_w_d   = lat_w_q;
		lat_h_d   = lat_h_q;
		drain_d   = drain_q;

		if (is_pix && first) begin
			lat_w_d   = w_new;
			lat_h_d   = h_new;
			out_col_d = '0;
			out_row_d = '0;
		end

		// output position advance, frame end resets the position counters and the drain flag
		if (emit) begin
			if (last) begin
				out_col_d = '0;
				out_row_d = '0;
				in_col_d  = '0;
				in_row_d  = '0;
				drain_d   = 1'b0;
			end else if (oc_inc >= {1'b0, w}) begin
				out_col_d = '0;
				out_row_d = out_row_q + 1'b1;
			end else begin
				out_col_d = oc_inc[CW-1:0];
			end
		end

		if (is_pix) begin
			if (c_inc >= {1'b0, w}) begin
				in_col_d = '0;
				if (r_inc >= {1'b0, h}) begin
					drain_d = 1'b1;
				end else begin
					in_row_d = r_inc[FH_BITS-1:0];
				end
			end else begin
				in_col_d = c_inc[CW-1:0];
			end
		end else if (is_flush && !final_flush) begin
			in_col_d = c_inc[CW-1:0];
		end
	end

	assign rd_en   = push;
	assign rd_addr = c[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			lat_w_q   <= CW'(2);
			lat_h_q   <= FH_BITS'(2);
			drain_q   <= 1'b0;
			ctl_s1    <= '0;
		end else begin
			in_col_q     <= in_col_d;
			in_row_q     <= in_row_d;
			out_col_q    <= out_col_d;
			out_row_q    <= out_row_d;
			lat_w_q      <= lat_w_d;
			lat_h_q      <= lat_h_d;
			drain_q      <= drain_d;
			ctl_s1.valid <= is_pix || is_flush;
			ctl_s1.wr    <= is_pix;
			ctl_s1.push  <= push;
			ctl_s1.emit  <= emit;
			ctl_s1.sel_l <= c_one && !final_flush;
			ctl_s1.sel_r <= !c_zero && !final_flush;
			ctl_s1.last  <= last;
			ctl_s1.src   <= src;
			ctl_s1.pix   <= item.pixel_in;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= c[AW-1:0];
	end

endmodule

// ===== design/sobth_window.sv =====
// sobth_window: line memory write-back, 3x3 window shift and neighbourhood selection
// depends on sobth_pkg; fed by sobth_ctrl and the line memory read port
module sobth_window #(
	parameter int AW = 10
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sobth_pkg::ctl_t                    ctl_s1,
	input  logic [AW-1:0]                      addr_s1,
	input  logic [sobth_pkg::LINE_BITS-1:0]    rdata,
	output logic                               we,
	output logic [AW-1:0]                      waddr,
	output logic [sobth_pkg::LINE_BITS-1:0]    wdata,
	output sobth_pkg::win_t                    win_s2
);
	import sobth_pkg::*;

	pix_t prev, prev2;
	col_t col_new;
	col_t win_q [3]; // [0] oldest column, [2] newest

	assign prev  = rdata[15:8];
	assign prev2 = rdata[7:0];

	always_comb begin
		case (ctl_s1.src)
			SRC_ROW0:  col_new = {ctl_s1.pix, ctl_s1.pix, ctl_s1.pix};
			SRC_ROW1:  col_new = {ctl_s1.pix, prev, prev};
			SRC_FULL:  col_new = {ctl_s1.pix, prev, prev2};
			SRC_DRAIN: col_new = {prev, prev, prev2};
			default:   col_new = {ctl_s1.pix, prev, prev2};
		endcase
	end

	// shift line: current line moves down into the older store
	assign we    = ctl_s1.valid && ctl_s1.wr;
	assign waddr = addr_s1;
	assign wdata = {ctl_s1.pix, prev};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q[0] <= '0;
			win_q[1] <= '0;
			win_q[2] <= '0;
		end else if (ctl_s1.valid && ctl_s1.push) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= col_new;
		end
	end

	// left is an old column, right the newest after the shift or the one before it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_s2 <= '0;
		end else begin
			win_s2.valid <= ctl_s1.valid && ctl_s1.emit;
			win_s2.last  <= ctl_s1.last;
			win_s2.l     <= ctl_s1.sel_l ? win_q[2] : win_q[1];
			win_s2.r     <= ctl_s1.sel_r ? col_new : win_q[2];
			win_s2.m_top <= win_q[2][0];
			win_s2.m_bot <= win_q[2][2];
		end
	end

endmodule

// ===== design/sobth_grad.sv =====
// sobth_grad: two-stage sobel gradient, magnitude and threshold compare
// depends on sobth_pkg; takes the neighbourhood from sobth_window
module sobth_grad (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sobth_pkg::win_t                  win_s2,
	input  logic [sobth_pkg::TH_BITS-1:0]    edge_threshold,
	output logic                             res_valid,
	output sobth_pkg::out_item_t             res_item
);
	import sobth_pkg::*;

	logic [9:0]                  sum_l, sum_r, sum_b, sum_t;
	logic signed [GRAD_BITS-1:0] gx, gy, gx_s3, gy_s3;
	logic [9:0]                  ax, ay;
	logic [10:0]                 mag;
	logic                        valid_s3, last_s3;

	always_comb begin
		sum_l = {2'b0, win_s2.l[0]} + {1'b0, win_s2.l[1], 1'b0} + {2'b0, win_s2.l[2]};
		sum_r = {2'b0, win_s2.r[0]} + {1'b0, win_s2.r[1], 1'b0} + {2'b0, win_s2.r[2]};
		sum_b = {2'b0, win_s2.l[2]} + {1'b0, win_s2.m_bot, 1'b0} + {2'b0, win_s2.r[2]};
		sum_t = {2'b0, win_s2.l[0]} + {1'b0, win_s2.m_top, 1'b0} + {2'b0, win_s2.r[0]};
		gx    = $signed({1'b0, sum_l}) - $signed({1'b0, sum_r});
		gy    = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= win_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		gx_s3   <= gx;
		gy_s3   <= gy;
		last_s3 <= win_s2.last;
	end

	// |gx| and |gy| stay within 1020
	always_comb begin
		ax  = gx_s3[GRAD_BITS-1] ? 10'(-gx_s3) : gx_s3[9:0];
		ay  = gy_s3[GRAD_BITS-1] ? 10'(-gy_s3) : gy_s3[9:0];
		mag = {1'b0, ax} + {1'b0, ay};
	end

	assign res_valid           = valid_s3;
	assign res_item.edge_pixel = (mag > edge_threshold) ? EDGE_ON : EDGE_OFF;
	assign res_item.frame_last = last_s3;

endmodule

// ===== design/sobth_fifo.sv =====
// sobth_fifo: small output queue that decouples result delivery from the pipeline
// depends on sobth_pkg
module sobth_fifo (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       push,
	input  sobth_pkg::out_item_t                       push_item,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output sobth_pkg::out_item_t                       out_data,
	output logic [$clog2(sobth_pkg::OUT_DEPTH+1)-1:0]  count
);
	import sobth_pkg::*;

	localparam int PW = $clog2(OUT_DEPTH);
	localparam int NW = $clog2(OUT_DEPTH + 1);

	out_item_t      mem_q [OUT_DEPTH];
	logic [PW-1:0]  head_q, tail_q;
	logic [NW-1:0]  count_q;
	logic           pop;

	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[head_q];
	assign pop       = out_valid && out_ready;
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[tail_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == PW'(OUT_DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (pop) begin
				head_q <= (head_q == PW'(OUT_DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/sobel_edge_threshold.sv =====
// sobel_edge_threshold: top level of the 3x3 sobel edge detector with binary threshold
// depends on sobth_pkg, sobth_ram, sobth_ctrl, sobth_window, sobth_grad, sobth_fifo

// Grey pixels enter in raster order, one transfer per clock while the output keeps up,
// and every pixel of the frame yields one edge pixel (255 when |Gx|+|Gy| exceeds
// edge_threshold, else 0), with borders padded by replicating the nearest edge pixel.
// The output for a pixel appears once the pixel one row and one column further on has
// been taken, so after the last pixel of a frame W+1 flush transfers (kind = 1) drain
// the remaining results; the final one carries frame_last. Frame size is sampled from
// the registers at the first pixel of a frame (width clamped to 2..MAX_WIDTH, height to
// at least 2); the threshold is used live. Flush transfers while pixels are expected,
// and pixels while draining, are taken and dropped. Both line stores share one
// MAX_WIDTH x 16 memory that is read as a transfer is taken and written back the cycle
// after; a result passes the ctl_s1, win_s2 and s3 registers and the output queue on
// its way out. The queue holds eight results and input ready drops only when it and
// the pipeline together would overfill, so the input keeps moving while results wait.
// The user must write registers only while the block is idle; the block does not enforce it.
module sobel_edge_threshold #(
	parameter int MAX_WIDTH = sobth_pkg::MAX_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// pixel input
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  sobth_pkg::in_item_t                   in_data,
	// edge output
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output sobth_pkg::out_item_t                  out_data,
	// register writes
	input  logic                                  cfg_we,
	input  logic [sobth_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [sobth_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import sobth_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int NW = $clog2(OUT_DEPTH + 1);

	// configuration registers
	logic [FW_BITS-1:0] frame_width_q;
	logic [FH_BITS-1:0] frame_height_q;
	logic [TH_BITS-1:0] edge_threshold_q;

	// internal wiring
	logic                 accept;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	ctl_t                 ctl_s1;
	logic [AW-1:0]        addr_s1;
	logic [LINE_BITS-1:0] line_rdata, line_wdata;
	logic                 line_we;
	logic [AW-1:0]        line_waddr;
	win_t                 win_s2;
	logic                 res_valid;
	out_item_t            res_item;
	logic [NW-1:0]        fifo_count;
	logic [NW:0]          fill;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q    <= FRAME_WIDTH_RST;
			frame_height_q   <= FRAME_HEIGHT_RST;
			edge_threshold_q <= EDGE_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:    frame_width_q    <= cfg_data[FW_BITS-1:0];
				REG_FRAME_HEIGHT:   frame_height_q   <= cfg_data[FH_BITS-1:0];
				REG_EDGE_THRESHOLD: edge_threshold_q <= cfg_data[TH_BITS-1:0];
				default:            ;
			endcase
		end
	end

	// credit check: queued results plus everything still in the pipeline
	assign fill     = {1'b0, fifo_count} + (NW+1)'(ctl_s1.valid) + (NW+1)'(win_s2.valid)
		+ (NW+1)'(res_valid);
	assign in_ready = (fill < (NW+1)'(OUT_DEPTH));
	assign accept   = in_valid && in_ready;

	sobth_ctrl #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.item         (in_data),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.ctl_s1       (ctl_s1),
		.addr_s1      (addr_s1)
	);

	// line memory: {previous row, row before that} per column
	sobth_ram #(
		.WIDTH (LINE_BITS),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (line_we),
		.waddr (line_waddr),
		.wdata (line_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (line_rdata)
	);

	sobth_window #(
		.AW (AW)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s1  (ctl_s1),
		.addr_s1 (addr_s1),
		.rdata   (line_rdata),
		.we      (line_we),
		.waddr   (line_waddr),
		.wdata   (line_wdata),
		.win_s2  (win_s2)
	);

	sobth_grad u_grad (
		.clk            (clk),
		.arst_n         (arst_n),
		.win_s2         (win_s2),
		.edge_threshold (edge_threshold_q),
		.res_valid      (res_valid),
		.res_item       (res_item)
	);

	sobth_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_item (res_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.count     (fifo_count)
	);

endmodule
